### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and codes of the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int MAX_HANDLES_DEF = 1024;
  localparam int GEN_BITS_DEF    = 16;

  // Operation codes
  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_DESTROY = 3'd1;
  localparam logic [2:0] OP_QUERY   = 3'd2;
  localparam logic [2:0] OP_BEGIN   = 3'd3;
  localparam logic [2:0] OP_END     = 3'd4;

  // Status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_MUTATION  = 3'd1;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd2;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [9:0]  handle_index_in;
    logic [15:0] handle_generation_in;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  handle_index_out;
    logic [15:0] handle_generation_out;
    logic        is_alive;
    logic [10:0] live_total;
    logic [31:0] structure_version;
  } rsp_t;

endpackage

### rtl/core/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Hands out index/generation handles, recycles freed indices through a LIFO
// free stack and tracks live count, structure version and read-phase depth.
// ----------------------------------------------------------------------------
// Usage: pulse start with a command while busy is low; the command transfers
// at that edge and busy rises. Exactly one result per command appears on rsp
// for a single cycle with done high; the receiver cannot stall, so capture it
// then. A command is accepted, then executed; done shows in the cycle after
// execute, in which the next command may already transfer. A create that
// reuses a freed index also passes through the pop state before execute,
// because the free-stack read and the following slot-table read are both
// synchronous. Slot state lives in one RAM holding {alive, generation} per
// index and the free stack in a second RAM. Each command reads, modifies and
// writes back in its execute cycle, so the next command always reads fresh
// data and no forwarding is needed. There is no clearing pass after reset:
// an index at or above the fresh mark was never handed out and reads as dead.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit #(
  parameter int MAX_HANDLES = gha_pkg::MAX_HANDLES_DEF,
  parameter int GEN_BITS    = gha_pkg::GEN_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gha_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output gha_pkg::rsp_t rsp
);

  localparam int          IDX_W = $clog2(MAX_HANDLES);
  localparam int          CNT_W = $clog2(MAX_HANDLES + 1);
  localparam int          ENT_W = GEN_BITS + 1;
  localparam logic [31:0] MAX_U = 32'(MAX_HANDLES);

  // Control state and counters
  gha_pkg::state_t state, state_next;
  logic [CNT_W-1:0] top, top_next;          // free-stack fill
  logic [CNT_W-1:0] fresh, fresh_next;      // next never-used index
  logic [CNT_W-1:0] live, live_next;
  logic [31:0]      version, version_next;
  logic [31:0]      depth, depth_next;

  // Latched command and the slot it works on
  gha_pkg::cmd_t    cmd_q;
  logic [IDX_W-1:0] slot;

  // Memory ports
  logic             ent_we;
  logic [IDX_W-1:0] ent_waddr, ent_raddr;
  logic [ENT_W-1:0] ent_wdata, ent_rdata;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr, stk_raddr;
  logic [IDX_W-1:0] stk_wdata, stk_rdata;

  // Datapath
  logic [31:0]         cmd_idx_ext, req_idx_ext, req_gen_ext;
  logic [IDX_W-1:0]    slot_in;
  logic [CNT_W-1:0]    top_m1;
  logic                ent_alive, in_fresh, hit, accept;
  logic [GEN_BITS-1:0] ent_gen, req_gen, gen_inc, gen_bump, new_gen;
  logic [IDX_W-1:0]    new_slot;
  logic [31:0]         new_slot_ext, new_gen_ext, live_ext;
  gha_pkg::rsp_t       res;

  assign busy   = (state != gha_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign cmd_idx_ext = 32'(cmd.handle_index_in);
  assign slot_in     = cmd_idx_ext[IDX_W-1:0];
  assign top_m1      = top - CNT_W'(1);

  // Read the stack top at transfer; read the slot entry at transfer, or at the
  // popped index once the stack data is back.
  assign stk_raddr = top_m1[IDX_W-1:0];
  assign ent_raddr = (state == gha_pkg::ST_POP) ? stk_rdata : slot_in;

  // Decode the entry read back for the execute cycle
  assign ent_alive   = ent_rdata[GEN_BITS];
  assign ent_gen     = ent_rdata[GEN_BITS-1:0];
  assign req_idx_ext = 32'(cmd_q.handle_index_in);
  assign req_gen_ext = 32'(cmd_q.handle_generation_in);
  assign req_gen     = req_gen_ext[GEN_BITS-1:0];
  // Only indices below the fresh mark were ever written; others are dead.
  assign in_fresh    = req_idx_ext < 32'(fresh);
  assign hit         = in_fresh && ent_alive && (ent_gen == req_gen);
  // Bump the generation on reuse, skipping zero on wrap
  assign gen_inc     = ent_gen + GEN_BITS'(1);
  assign gen_bump    = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

  gha_ram #(.WIDTH(ENT_W), .DEPTH(MAX_HANDLES)) u_ent_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  gha_ram #(.WIDTH(IDX_W), .DEPTH(MAX_HANDLES)) u_stk_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  // Next state, memory writes and the result
  always_comb begin
    state_next   = state;
    top_next     = top;
    fresh_next   = fresh;
    live_next    = live;
    version_next = version;
    depth_next   = depth;
    ent_we       = 1'b0;
    ent_waddr    = slot;
    ent_wdata    = {1'b0, ent_gen};
    stk_we       = 1'b0;
    stk_waddr    = top[IDX_W-1:0];
    stk_wdata    = slot;
    new_slot     = '0;
    new_gen      = '0;
    res          = '0;
    res.status   = gha_pkg::STAT_OK;

    case (state)
      gha_pkg::ST_IDLE: begin
        if (accept) begin
          // Detour through the stack read only for a create that reuses
          if (cmd.operation == gha_pkg::OP_CREATE && depth == '0 && top != '0) begin
            state_next = gha_pkg::ST_POP;
          end else begin
            state_next = gha_pkg::ST_EXEC;
          end
        end
      end
      gha_pkg::ST_POP: begin
        state_next = gha_pkg::ST_EXEC;
      end
      gha_pkg::ST_EXEC: begin
        state_next = gha_pkg::ST_IDLE;
        case (cmd_q.operation)
          gha_pkg::OP_CREATE: begin
            if (depth != '0) begin
              res.status = gha_pkg::STAT_MUTATION;
            end else if (top != '0) begin
              new_slot     = slot;
              new_gen      = gen_bump;
              top_next     = top_m1;
              ent_we       = 1'b1;
              live_next    = live + CNT_W'(1);
              version_next = version + 32'd1;
            end else if (32'(fresh) < MAX_U) begin
              new_slot     = fresh[IDX_W-1:0];
              new_gen      = GEN_BITS'(1);
              fresh_next   = fresh + CNT_W'(1);
              ent_we       = 1'b1;
              live_next    = live + CNT_W'(1);
              version_next = version + 32'd1;
            end else begin
              res.status = gha_pkg::STAT_FULL;
            end
            ent_waddr = new_slot;
            ent_wdata = {1'b1, new_gen};
          end
          gha_pkg::OP_DESTROY: begin
            if (depth != '0) begin
              res.status = gha_pkg::STAT_MUTATION;
            end else if (hit) begin
              // Clear alive, keep the generation, push the index
              ent_we       = 1'b1;
              version_next = version + 32'd1;
              if (live != '0) begin
                live_next = live - CNT_W'(1);
              end
              if (32'(top) < MAX_U) begin
                stk_we   = 1'b1;
                top_next = top + CNT_W'(1);
              end
            end
          end
          gha_pkg::OP_QUERY: begin
            res.is_alive = hit;
          end
          gha_pkg::OP_BEGIN: begin
            if (depth == '1) begin
              res.status = gha_pkg::STAT_OVERFLOW;
            end else begin
              depth_next = depth + 32'd1;
            end
          end
          gha_pkg::OP_END: begin
            if (depth == '0) begin
              res.status = gha_pkg::STAT_UNDERFLOW;
            end else begin
              depth_next = depth - 32'd1;
            end
          end
          default: begin
            // Unknown operation: report plain values only
          end
        endcase
      end
      default: begin
        state_next = gha_pkg::ST_IDLE;
      end
    endcase

    new_slot_ext              = 32'(new_slot);
    new_gen_ext               = 32'(new_gen);
    live_ext                  = 32'(live_next);
    res.handle_index_out      = new_slot_ext[9:0];
    res.handle_generation_out = new_gen_ext[15:0];
    res.live_total            = live_ext[10:0];
    res.structure_version     = version_next;
  end

  // State register, counters and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gha_pkg::ST_IDLE;
      top     <= '0;
      fresh   <= '0;
      live    <= '0;
      version <= '0;
      depth   <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      top     <= top_next;
      fresh   <= fresh_next;
      live    <= live_next;
      version <= version_next;
      depth   <= depth_next;
      done    <= (state == gha_pkg::ST_EXEC);
    end
  end

  // Payload registers: hold the command and slot, capture the result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      slot  <= slot_in;
    end else if (state == gha_pkg::ST_POP) begin
      slot <= stk_rdata;
    end
    if (state == gha_pkg::ST_EXEC) begin
      rsp <= res;
    end
  end

endmodule

### rtl/core/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks of the handle allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gha_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input gha_pkg::rsp_t rsp
);

  // A transfer makes the block busy
  `CHK_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // A result only follows a busy cycle and leaves the block ready
  `CHK_SAME(a_done_after_busy, clk, rst, done, $past(busy) && !busy)

  // A query answer carries no created handle and no error
  `CHK_SAME(a_alive_clean, clk, rst, done && rsp.is_alive,
            rsp.status == gha_pkg::STAT_OK && rsp.handle_generation_out == '0)

  // An error creates nothing: its handle is index zero, generation zero
  `CHK_SAME(a_err_no_handle, clk, rst, done && rsp.status != gha_pkg::STAT_OK,
            rsp.handle_generation_out == '0 && rsp.handle_index_out == '0)

endmodule

bind generational_handle_allocator_unit gha_checker u_gha_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for generational_handle_allocator_unit. A driver feeds
// commands from a backlog queue, a shadow allocator predicts every response at
// the transfer, and a monitor compares each done strobe with the oldest
// prediction. Phases: directed corner cases, filling the table, random mixes
// under several sender idle rates, and a short recycle loop on one index that
// keeps bumping its generation.
// ----------------------------------------------------------------------------
module testbench;

  localparam int N_HANDLES   = gha_pkg::MAX_HANDLES_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RECYCLE_LEN = 8;
  localparam int RANDOM_LEN  = 180;

  // Codes the block decodes as no operation
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  logic          clk;
  logic          rst   = 1'b1;
  logic          start = 1'b0;
  gha_pkg::cmd_t cmd   = '0;
  logic          busy;
  logic          done;
  gha_pkg::rsp_t rsp;

  generational_handle_allocator_unit i_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  // --------------------------------------------------------------------------
  // Shadow allocator state
  // --------------------------------------------------------------------------
  logic [15:0] gen_of     [N_HANDLES] = '{default: '0};
  bit          alive_flag [N_HANDLES] = '{default: 1'b0};
  logic [9:0]  free_list  [N_HANDLES] = '{default: '0};
  int unsigned stack_top   = 0;
  int unsigned fresh_mark  = 0;
  int unsigned live_count  = 0;
  logic [31:0] version_count = '0;
  logic [31:0] phase_depth   = '0;

  gha_pkg::cmd_t cmd_backlog[$];
  gha_pkg::rsp_t pending_responses[$];

  int sender_idle_pct = 0;
  int tracked_depth   = 0;
  int cycle_count     = 0;
  int error_count     = 0;
  int cmds_sent       = 0;
  int rsps_checked    = 0;
  int creates_granted = 0;
  int full_refusals   = 0;
  int phase_refusals  = 0;
  int gen_wraps       = 0;
  int alive_answers   = 0;

  // Apply one command to the shadow state and return the response it must give.
  function automatic gha_pkg::rsp_t allocator_predict(gha_pkg::cmd_t c);
    gha_pkg::rsp_t r;
    logic [9:0]    ix;
    logic [15:0]   g;
    bit            hit;
    r   = '0;
    ix  = c.handle_index_in;
    hit = alive_flag[ix] && (gen_of[ix] == c.handle_generation_in);
    case (c.operation)
      gha_pkg::OP_CREATE: begin
        if (phase_depth != '0) begin
          r.status = gha_pkg::STAT_MUTATION;
          phase_refusals++;
        end else if (stack_top != 0 || fresh_mark < N_HANDLES) begin
          if (stack_top != 0) begin
            // Reuse the most recently freed slot, skipping generation zero
            stack_top--;
            ix = free_list[stack_top];
            g  = gen_of[ix] + 16'd1;
            if (g == '0) begin
              g = 16'd1;
              gen_wraps++;
            end
          end else begin
            ix = fresh_mark[9:0];
            g  = 16'd1;
            fresh_mark++;
          end
          gen_of[ix]     = g;
          alive_flag[ix] = 1'b1;
          live_count++;
          version_count++;
          creates_granted++;
          r.handle_index_out      = ix;
          r.handle_generation_out = g;
        end else begin
          r.status = gha_pkg::STAT_FULL;
          full_refusals++;
        end
      end
      gha_pkg::OP_DESTROY: begin
        if (phase_depth != '0) begin
          r.status = gha_pkg::STAT_MUTATION;
          phase_refusals++;
        end else if (hit) begin
          alive_flag[ix] = 1'b0;
          if (live_count > 0) live_count--;
          version_count++;
          if (stack_top < N_HANDLES) begin
            free_list[stack_top] = ix;
            stack_top++;
          end
        end
      end
      gha_pkg::OP_QUERY: begin
        r.is_alive = hit;
        if (hit) alive_answers++;
      end
      gha_pkg::OP_BEGIN: begin
        if (phase_depth == '1) r.status = gha_pkg::STAT_OVERFLOW;
        else phase_depth++;
      end
      gha_pkg::OP_END: begin
        if (phase_depth == '0) r.status = gha_pkg::STAT_UNDERFLOW;
        else phase_depth--;
      end
      default: ;
    endcase
    r.live_total        = live_count[10:0];
    r.structure_version = version_count;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: predict at each transfer, then present the next command or idle
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_responses.insert(pending_responses.size(), allocator_predict(cmd));
        cmds_sent++;
      end
      // Hold a command that has not transferred yet; otherwise pick the next one
      if (start && busy) begin
        start <= 1'b1;
      end else if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        cmd   <= cmd_backlog.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every done strobe must match the oldest prediction field by field
  // --------------------------------------------------------------------------
  task automatic check_response(gha_pkg::rsp_t got);
    gha_pkg::rsp_t want;
    if (pending_responses.size() == 0) begin
      $error("result with no command outstanding: %p", got);
      error_count++;
      return;
    end
    want = pending_responses.pop_front();
    rsps_checked++;
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      error_count++;
    end
    if (got.handle_index_out !== want.handle_index_out) begin
      $error("handle_index_out: expected %0d, got %0d",
             want.handle_index_out, got.handle_index_out);
      error_count++;
    end
    if (got.handle_generation_out !== want.handle_generation_out) begin
      $error("handle_generation_out: expected %0d, got %0d",
             want.handle_generation_out, got.handle_generation_out);
      error_count++;
    end
    if (got.is_alive !== want.is_alive) begin
      $error("is_alive: expected %0d, got %0d", want.is_alive, got.is_alive);
      error_count++;
    end
    if (got.live_total !== want.live_total) begin
      $error("live_total: expected %0d, got %0d", want.live_total, got.live_total);
      error_count++;
    end
    if (got.structure_version !== want.structure_version) begin
      $error("structure_version: expected %0d, got %0d",
             want.structure_version, got.structure_version);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) check_response(rsp);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Append a command and track the read-phase depth it leaves behind.
  task automatic queue_cmd(logic [2:0] op, logic [9:0] ix, logic [15:0] g);
    gha_pkg::cmd_t c;
    c.operation            = op;
    c.handle_index_in      = ix;
    c.handle_generation_in = g;
    cmd_backlog.insert(cmd_backlog.size(), c);
    if (op == gha_pkg::OP_BEGIN) tracked_depth++;
    else if (op == gha_pkg::OP_END && tracked_depth > 0) tracked_depth--;
  endtask

  // Hold off until the backlog is empty and every response has come back.
  task automatic wait_until_idle();
    while (cmd_backlog.size() != 0 || start || pending_responses.size() != 0)
      @(negedge clk);
  endtask

  // Aim mostly at live handles, sometimes one generation off, sometimes anywhere.
  task automatic queue_handle_op(logic [2:0] op);
    int          r;
    int          ix;
    logic [15:0] g;
    r  = $urandom_range(99);
    ix = $urandom_range(N_HANDLES - 1);
    g  = 16'($urandom_range(65535));
    if (r < 85 && fresh_mark != 0) begin
      ix = $urandom_range(fresh_mark - 1);
      for (int k = 0; k < 8 && !alive_flag[ix]; k++) ix = $urandom_range(fresh_mark - 1);
      g = gen_of[ix];
      if (r >= 70) g = $urandom_range(1) ? g + 16'd1 : g - 16'd1;
    end
    queue_cmd(op, 10'(ix), g);
  endtask

  task automatic queue_random_cmd();
    int r;
    r = $urandom_range(99);
    if (tracked_depth != 0) begin
      // Inside a read phase: mostly lookups, then close it; a few refused mutations
      if (r < 50)      queue_handle_op(gha_pkg::OP_QUERY);
      else if (r < 80) queue_handle_op(gha_pkg::OP_END);
      else if (r < 85) queue_handle_op(gha_pkg::OP_BEGIN);
      else if (r < 92) queue_handle_op(gha_pkg::OP_CREATE);
      else             queue_handle_op(gha_pkg::OP_DESTROY);
    end else begin
      if (r < 35)      queue_handle_op(gha_pkg::OP_CREATE);
      else if (r < 65) queue_handle_op(gha_pkg::OP_DESTROY);
      else if (r < 85) queue_handle_op(gha_pkg::OP_QUERY);
      else if (r < 93) queue_handle_op(gha_pkg::OP_BEGIN);
      else if (r < 95) queue_handle_op(gha_pkg::OP_END);
      else             queue_cmd(3'($urandom_range(7)), 10'($urandom_range(1023)),
                                 16'($urandom_range(65535)));
    end
  endtask

  task automatic run_random(int n, int idle_pct);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < n; i++) begin
      // Keep the backlog short so handle picks follow the shadow state closely
      while (cmd_backlog.size() >= 4) @(negedge clk);
      queue_random_cmd();
    end
    wait_until_idle();
  endtask

  function automatic int any_live_index();
    for (int k = 0; k < N_HANDLES; k++)
      if (alive_flag[k]) return k;
    return -1;
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    int          slot;
    logic [15:0] g;
    int          fill_len;

    @(negedge clk);
    while (rst) @(negedge clk);

    // Directed: empty table, underflow, nesting, refusals, stale handles, spare codes
    sender_idle_pct = 0;
    queue_cmd(gha_pkg::OP_QUERY,   10'd0,    16'd1);
    queue_cmd(gha_pkg::OP_END,     10'd0,    16'd0);
    queue_cmd(gha_pkg::OP_CREATE,  10'd0,    16'd0);
    queue_cmd(gha_pkg::OP_CREATE,  10'd0,    16'd0);
    queue_cmd(gha_pkg::OP_QUERY,   10'd0,    16'd1);
    queue_cmd(gha_pkg::OP_QUERY,   10'd0,    16'hFFFF);
    queue_cmd(gha_pkg::OP_QUERY,   10'd1023, 16'hFFFF);
    queue_cmd(gha_pkg::OP_BEGIN,   10'd0,    16'd0);
    queue_cmd(gha_pkg::OP_BEGIN,   10'd1023, 16'hFFFF);
    queue_cmd(gha_pkg::OP_CREATE,  10'd0,    16'd0);
    queue_cmd(gha_pkg::OP_DESTROY, 10'd0,    16'd1);
    queue_cmd(gha_pkg::OP_DESTROY, 10'd1023, 16'd0);
    queue_cmd(gha_pkg::OP_QUERY,   10'd1,    16'd1);
    queue_cmd(gha_pkg::OP_END,     10'd0,    16'd0);
    queue_cmd(gha_pkg::OP_END,     10'd0,    16'd0);
    queue_cmd(gha_pkg::OP_DESTROY, 10'd0,    16'd1);
    queue_cmd(gha_pkg::OP_DESTROY, 10'd0,    16'd1);
    queue_cmd(gha_pkg::OP_DESTROY, 10'd1,    16'd2);
    queue_cmd(gha_pkg::OP_CREATE,  10'd0,    16'd0);
    queue_cmd(gha_pkg::OP_QUERY,   10'd0,    16'd2);
    queue_cmd(OP_SPARE_A,          10'd1023, 16'hFFFF);
    queue_cmd(OP_SPARE_B,          10'd1023, 16'hFFFF);
    queue_cmd(OP_SPARE_C,          10'd0,    16'd0);
    wait_until_idle();

    // Fill every slot, then hit the full table a few times
    fill_len = N_HANDLES - fresh_mark + stack_top + 3;
    for (int i = 0; i < fill_len; i++) queue_cmd(gha_pkg::OP_CREATE, 10'd0, 16'd0);
    wait_until_idle();

    // Random mixes; the receiver cannot stall, so only the sender idles
    run_random(RANDOM_LEN, 0);
    run_random(RANDOM_LEN, 75);
    run_random(RANDOM_LEN, 24);

    // Close any open read phase and find a live handle to recycle
    sender_idle_pct = 0;
    while (tracked_depth > 0) queue_cmd(gha_pkg::OP_END, 10'd0, 16'd0);
    wait_until_idle();
    slot = any_live_index();
    if (slot < 0) begin
      queue_cmd(gha_pkg::OP_CREATE, 10'd0, 16'd0);
      wait_until_idle();
      slot = any_live_index();
    end

    // Destroy and recreate one slot a few times, bumping its generation each round
    g = gen_of[slot];
    for (int i = 0; i < RECYCLE_LEN; i++) begin
      while (cmd_backlog.size() >= 16) @(negedge clk);
      queue_cmd(gha_pkg::OP_DESTROY, 10'(slot), g);
      queue_cmd(gha_pkg::OP_CREATE, 10'd0, 16'd0);
      g = g + 16'd1;
      if (g == '0) g = 16'd1;
    end
    wait_until_idle();

    // Let any stray result show up before the verdict
    repeat (10) @(posedge clk);

    $display("Sent %0d commands, checked %0d results;", cmds_sent, rsps_checked);
    $display("%0d creates granted, %0d alive queries.", creates_granted, alive_answers);
    $display("Refusals: %0d table full, %0d in read phase; %0d generation wraps.",
             full_refusals, phase_refusals, gen_wraps);
    if (error_count == 0 && pending_responses.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/gha_pkg.sv
rtl/core/gha_ram.sv
rtl/core/generational_handle_allocator_unit.sv
rtl/core/gha_checker.sv
sim/testbench.sv
